[rtl/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam int MAX_PAYLOAD = 8;
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = $clog2(MAX_PAYLOAD);

	localparam logic [7:0] HEADER_RESET = 8'hCE;
	localparam logic [7:0] MAX_CMD = 8'h03;
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_CMD  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_CHASSIS = 2'd1,
		CMD_GIMBAL  = 2'd2,
		CMD_FIRE    = 2'd3
	} cmd_t;

	typedef logic [MAX_PAYLOAD-1:0][7:0] payload_t;

	// Frame completion event from the parser to the hold stage.
	typedef struct packed {
		logic     done;
		cmd_t     code;
		payload_t payload;
	} frame_evt_t;

endpackage

[rtl/cfp_if.sv]
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channels for received bytes and for parsed command results.
// ----------------------------------------------------------------------------
interface cfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_cmd;
	logic [7:0]  chassis_dir;
	logic [31:0] yaw_bits;
	logic [31:0] pitch_bits;
	logic        gimbal_update;
	logic [7:0]  fire_cmd;

	modport source (
		output valid, output frame_cmd, output chassis_dir, output yaw_bits,
		output pitch_bits, output gimbal_update, output fire_cmd, input ready
	);
	modport sink (
		input valid, input frame_cmd, input chassis_dir, input yaw_bits,
		input pitch_bits, input gimbal_update, input fire_cmd, output ready
	);
endinterface

[rtl/cfp_parser.sv]
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state machine and payload buffer; flags each completed frame.
// ----------------------------------------------------------------------------
module cfp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             header_byte,
	output cfp_pkg::frame_evt_t    evt
);

	cfp_pkg::phase_t phase_q, phase_d;
	logic [cfp_pkg::CNT_W-1:0] len_q;
	cfp_pkg::cmd_t code_q;
	logic [cfp_pkg::CNT_W-1:0] cnt_q;
	cfp_pkg::payload_t buf_q;
	cfp_pkg::payload_t buf_d;

	logic [cfp_pkg::CNT_W-1:0] cnt_inc;
	logic done;
	logic to_hunt;
	logic len_ld;
	logic cmd_ld;
	logic data_step;

	assign cnt_inc = cnt_q + cfp_pkg::CNT_W'(1);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				cfp_pkg::PH_HUNT: begin
					if (rx_byte == header_byte)
						phase_d = cfp_pkg::PH_LEN;
				end
				cfp_pkg::PH_LEN: begin
					phase_d = (rx_byte <= cfp_pkg::MAX_LEN) ? cfp_pkg::PH_CMD
						: cfp_pkg::PH_HUNT;
				end
				cfp_pkg::PH_CMD: begin
					if (rx_byte <= cfp_pkg::MAX_CMD && len_q != '0)
						phase_d = cfp_pkg::PH_DATA;
					else
						phase_d = cfp_pkg::PH_HUNT;
				end
				cfp_pkg::PH_DATA: begin
					if (cnt_inc >= len_q)
						phase_d = cfp_pkg::PH_HUNT;
				end
				default: phase_d = cfp_pkg::PH_HUNT;
			endcase
		end
	end

	// Phase outputs.
	always_comb begin
		done = 1'b0;
		to_hunt = 1'b0;
		len_ld = 1'b0;
		cmd_ld = 1'b0;
		data_step = 1'b0;
		if (accept) begin
			unique case (phase_q)
				cfp_pkg::PH_HUNT: ;
				cfp_pkg::PH_LEN: begin
					if (rx_byte <= cfp_pkg::MAX_LEN)
						len_ld = 1'b1;
					else
						to_hunt = 1'b1;
				end
				cfp_pkg::PH_CMD: begin
					if (rx_byte <= cfp_pkg::MAX_CMD) begin
						cmd_ld = 1'b1;
						if (len_q == '0) begin
							done = 1'b1;
							to_hunt = 1'b1;
						end
					end else begin
						to_hunt = 1'b1;
					end
				end
				cfp_pkg::PH_DATA: begin
					data_step = 1'b1;
					if (cnt_inc >= len_q) begin
						done = 1'b1;
						to_hunt = 1'b1;
					end
				end
				default: to_hunt = 1'b1;
			endcase
		end
	end

	// Payload buffer with this cycle's byte folded in.
	always_comb begin
		buf_d = buf_q;
		if (data_step && cnt_q < cfp_pkg::CNT_W'(cfp_pkg::MAX_PAYLOAD))
			buf_d[cnt_q[cfp_pkg::IDX_W-1:0]] = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfp_pkg::PH_HUNT;
			len_q <= '0;
			code_q <= cfp_pkg::CMD_NONE;
			cnt_q <= '0;
			buf_q <= '0;
		end else begin
			phase_q <= phase_d;
			buf_q <= buf_d;
			if (to_hunt) begin
				len_q <= '0;
				code_q <= cfp_pkg::CMD_NONE;
				cnt_q <= '0;
			end else if (len_ld) begin
				len_q <= rx_byte[cfp_pkg::CNT_W-1:0];
			end else if (cmd_ld) begin
				code_q <= cfp_pkg::cmd_t'(rx_byte[1:0]);
				cnt_q <= '0;
			end else if (data_step) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	assign evt.done = done;
	assign evt.code = (phase_q == cfp_pkg::PH_CMD) ? cfp_pkg::cmd_t'(rx_byte[1:0]) : code_q;
	assign evt.payload = buf_d;

endmodule

[rtl/cfp_hold.sv]
// ----------------------------------------------------------------------------
// cfp_hold
// Held command values and the result register.
// ----------------------------------------------------------------------------
module cfp_hold (
	input  logic                clk,
	input  logic                arst_n,
	input  cfp_pkg::frame_evt_t evt,
	cfp_res_if.source           res
);

	logic [7:0]    dir_q;
	logic [31:0]   yaw_q;
	logic [31:0]   pitch_q;
	logic [7:0]    fire_q;
	cfp_pkg::cmd_t cmd_q;
	logic          upd_q;
	logic          valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
			fire_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (evt.done) begin
				valid_q <= 1'b1;
				unique case (evt.code)
					cfp_pkg::CMD_NONE: ;
					cfp_pkg::CMD_CHASSIS: dir_q <= evt.payload[0];
					cfp_pkg::CMD_GIMBAL: begin
						yaw_q <= {evt.payload[3], evt.payload[2],
							evt.payload[1], evt.payload[0]};
						pitch_q <= {evt.payload[7], evt.payload[6],
							evt.payload[5], evt.payload[4]};
					end
					cfp_pkg::CMD_FIRE: fire_q <= evt.payload[0];
					default: ;
				endcase
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload; needs no reset.
	always_ff @(posedge clk) begin
		if (evt.done) begin
			cmd_q <= evt.code;
			upd_q <= (evt.code == cfp_pkg::CMD_GIMBAL);
		end
	end

	assign res.valid = valid_q;
	assign res.frame_cmd = cmd_q;
	assign res.chassis_dir = dir_q;
	assign res.yaw_bits = yaw_q;
	assign res.pitch_bits = pitch_q;
	assign res.gimbal_update = upd_q;
	assign res.fire_cmd = fire_q;

endmodule

[rtl/command_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// command_frame_parser_core: one received byte per cycle while results are
// taken; a frame's result appears in the cycle after its last byte is taken.
// The single parse stage sets that rate.
// Reset is asynchronous: parser to hunt, held commands zero, header 0xCE.
// ----------------------------------------------------------------------------
module command_frame_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	cfp_rx_if.sink     rx,
	cfp_res_if.source  res
);

	// The header byte, the only configuration register, feeds the hunt compare
	// directly; it is to be written only while the parser is idle (unchecked).
	logic [7:0] header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			header_q <= cfp_pkg::HEADER_RESET;
		else if (cfg_we)
			header_q <= cfg_wdata;
	end

	// A byte is taken whenever the result register is empty or is being
	// drained in the same cycle. Since a byte can complete at most one frame,
	// the result register is then always free for whatever it produces. Bytes
	// that complete no frame are also held off while a result waits, which
	// keeps the control simple and costs nothing at serial rates.
	logic accept;

	assign rx.ready = !res.valid || res.ready;
	assign accept = rx.valid && rx.ready;

	// The parser walks hunt, length, command and data phases, keeps the
	// payload buffer and reports a completed frame together with the buffer
	// contents including the byte just taken.
	cfp_pkg::frame_evt_t evt;

	cfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx.rx_byte),
		.header_byte(header_q),
		.evt        (evt)
	);

	// The hold stage applies the frame's command to the held values at the
	// same edge and presents them with the command code as one result item.
	cfp_hold u_hold (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.res   (res)
	);

	// A frame can only complete on a byte that was actually taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |-> accept)
		else $error("frame completed without an accepted byte");

	// Every completed frame shows up as a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |=> res.valid)
		else $error("completed frame produced no result");

	// A drained result with no new frame behind it leaves the port empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !evt.done) |=> !res.valid)
		else $error("result repeated after it was taken");

	// The gimbal flag goes with the gimbal command and nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.gimbal_update == (res.frame_cmd == cfp_pkg::CMD_GIMBAL)))
		else $error("gimbal flag does not match command code");

endmodule

[dv/tb_command_frame_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_parser_core
// Drives received bytes into the frame parser and checks every command result
// against an in-order prediction. Runs a directed set of frames, then random
// frames, noise and broken frames under several header values, with random
// gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_command_frame_parser_core;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_BYTES = 600;
	localparam int DRAIN_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	// One command result as seen on the result channel.
	typedef struct packed {
		cfp_pkg::cmd_t cmd;
		logic [7:0]    dir;
		logic [31:0]   yaw;
		logic [31:0]   pitch;
		logic          upd;
		logic [7:0]    fire;
	} cmd_result_t;

	// The scoreboard keeps its own copy of the parser state. Every accepted
	// byte is run through it, and a completed frame pushes the command values
	// that the block should report for it.
	class frame_scoreboard;
		logic [7:0]       header;
		cfp_pkg::phase_t  phase;
		logic [3:0]       length;
		cfp_pkg::cmd_t    code;
		logic [3:0]       count;
		logic [7:0]       payload [cfp_pkg::MAX_PAYLOAD];
		logic [7:0]       dir;
		logic [31:0]      yaw;
		logic [31:0]      pitch;
		logic [7:0]       fire;
		cmd_result_t      frames_due [$];
		int               fails;
		int               frames_checked;

		function new();
			header = cfp_pkg::HEADER_RESET;
			dir = '0;
			yaw = '0;
			pitch = '0;
			fire = '0;
			fails = 0;
			frames_checked = 0;
			foreach (payload[i])
				payload[i] = '0;
			to_hunt();
		endfunction

		function void to_hunt();
			phase = cfp_pkg::PH_HUNT;
			length = '0;
			code = cfp_pkg::CMD_NONE;
			count = '0;
		endfunction

		// Apply the completed frame to the held values and queue the result.
		function void close_frame();
			cmd_result_t r;
			r.upd = 1'b0;
			case (code)
				cfp_pkg::CMD_CHASSIS: begin
					dir = payload[0];
				end
				cfp_pkg::CMD_GIMBAL: begin
					yaw = {payload[3], payload[2], payload[1], payload[0]};
					pitch = {payload[7], payload[6], payload[5], payload[4]};
					r.upd = 1'b1;
				end
				cfp_pkg::CMD_FIRE: begin
					fire = payload[0];
				end
				default: begin
				end
			endcase
			r.cmd = code;
			r.dir = dir;
			r.yaw = yaw;
			r.pitch = pitch;
			r.fire = fire;
			frames_due.push_back(r);
			to_hunt();
		endfunction

		function void note_byte(logic [7:0] b);
			case (phase)
				cfp_pkg::PH_HUNT: begin
					if (b == header)
						phase = cfp_pkg::PH_LEN;
				end
				cfp_pkg::PH_LEN: begin
					if (b <= cfp_pkg::MAX_LEN) begin
						length = b[3:0];
						phase = cfp_pkg::PH_CMD;
					end else
						to_hunt();
				end
				cfp_pkg::PH_CMD: begin
					if (b <= cfp_pkg::MAX_CMD) begin
						code = cfp_pkg::cmd_t'(b[1:0]);
						count = '0;
						if (length == 0)
							close_frame();
						else
							phase = cfp_pkg::PH_DATA;
					end else
						to_hunt();
				end
				cfp_pkg::PH_DATA: begin
					payload[count[cfp_pkg::IDX_W-1:0]] = b;
					count = count + 4'd1;
					if (count >= length)
						close_frame();
				end
			endcase
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			fails++;
		endtask

		task check_result(cmd_result_t got);
			cmd_result_t want;
			if (frames_due.size() == 0) begin
				report($sformatf("unexpected result, cmd %0d", got.cmd));
				return;
			end
			want = frames_due.pop_front();
			frames_checked++;
			if (got.cmd !== want.cmd)
				report($sformatf("frame_cmd got %0d want %0d", got.cmd, want.cmd));
			if (got.dir !== want.dir)
				report($sformatf("chassis_dir got %h want %h", got.dir, want.dir));
			if (got.yaw !== want.yaw)
				report($sformatf("yaw_bits got %h want %h", got.yaw, want.yaw));
			if (got.pitch !== want.pitch)
				report($sformatf("pitch_bits got %h want %h", got.pitch, want.pitch));
			if (got.upd !== want.upd)
				report($sformatf("gimbal_update got %b want %b", got.upd, want.upd));
			if (got.fire !== want.fire)
				report($sformatf("fire_cmd got %h want %h", got.fire, want.fire));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	cfp_rx_if  rx_ch ();
	cfp_res_if res_ch ();

	command_frame_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx       (rx_ch),
		.res      (res_ch)
	);

	frame_scoreboard sb;
	int   cycles;
	int   bytes_sent;
	int   burst_left;
	int   headers_used;
	logic hold_rx;

	// 4 ns clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("command_frame_parser_core verification failed");
			$finish;
		end
	end

	// Result monitor. Outputs are sampled at the rising edge, where the ready
	// driven at the previous falling edge is stable.
	always @(posedge clk) begin
		cmd_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.cmd = cfp_pkg::cmd_t'(res_ch.frame_cmd);
			got.dir = res_ch.chassis_dir;
			got.yaw = res_ch.yaw_bits;
			got.pitch = res_ch.pitch_bits;
			got.upd = res_ch.gimbal_update;
			got.fire = res_ch.fire_cmd;
			sb.check_result(got);
		end
	end

	// Result-side stall generator. It cycles through short random ready
	// patterns, with an always-ready pattern now and then so that stretches
	// run at full rate. When hold_rx is raised it keeps ready low for a long
	// counted stretch so that the block backs up into the byte channel.
	initial begin : result_stall
		int          pat_left;
		int          hold_count;
		logic [15:0] pat;
		pat_left = 0;
		hold_count = 0;
		pat = '1;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				res_ch.ready = 1'b0;
				hold_count++;
				if (hold_count >= HOLD_CYCLES) begin
					hold_count = 0;
					hold_rx = 1'b0;
				end
			end else begin
				if (pat_left == 0) begin
					pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
					pat_left = $urandom_range(8, 64);
				end
				res_ch.ready = pat[0];
				pat = {pat[0], pat[15:1]};
				pat_left--;
			end
		end
	end

	// Offer one byte and wait until the block takes it. The sender works in
	// bursts; when a burst runs out it idles for a random gap first. Valid is
	// left high after the handshake, so back-to-back bytes keep it asserted.
	task send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				rx_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Wait until every predicted result has come back, with a bound so that a
	// lost result shows up as a leftover rather than a hang.
	task drain_results();
		int n;
		n = 0;
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Header changes happen only with the block idle: byte channel quiet,
	// nothing outstanding, and a settle time for a byte that may still be
	// in flight without a result.
	task write_header(input logic [7:0] h);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = h;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.header = h;
		headers_used++;
	endtask

	// One random frame. Most are well formed with random content; some carry
	// a bad length or a bad command, some are cut short so that the next
	// frame's bytes land in the payload, and noise bytes sit between frames.
	task send_frame();
		int         kind;
		int         len;
		int         cut;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		send_byte(sb.header);
		if (kind < 8) begin
			send_byte(8'($urandom_range(cfp_pkg::MAX_PAYLOAD + 1, 255)));
			return;
		end
		len = ($urandom_range(0, 3) == 0) ? cfp_pkg::MAX_PAYLOAD
			: $urandom_range(0, cfp_pkg::MAX_PAYLOAD);
		send_byte(8'(len));
		if (kind < 14) begin
			send_byte(8'($urandom_range(int'(cfp_pkg::MAX_CMD) + 1, 255)));
			return;
		end
		send_byte(8'($urandom_range(0, int'(cfp_pkg::MAX_CMD))));
		cut = (kind < 20 && len > 0) ? $urandom_range(0, len - 1) : len;
		for (int i = 0; i < cut; i++) begin
			b = ($urandom_range(0, 9) == 0) ? sb.header : 8'($urandom);
			send_byte(b);
		end
	endtask

	initial begin : stimulus
		logic [7:0] header_plan [4];
		int         target;
		sb = new();
		cycles = 0;
		bytes_sent = 0;
		burst_left = 0;
		headers_used = 1;
		hold_rx = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset header value.
		// A zero-length frame completes straight after its command byte.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h00);
		send_byte(8'(cfp_pkg::CMD_NONE));
		// A length just past the payload limit sends the parser back to hunting.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(cfp_pkg::MAX_LEN + 8'd1);
		// A command code just past the last one does the same.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h00);
		send_byte(cfp_pkg::MAX_CMD + 8'd1);
		// A full gimbal frame with the header value and both byte extremes
		// inside the payload; the header byte there is plain data.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(cfp_pkg::MAX_LEN);
		send_byte(8'(cfp_pkg::CMD_GIMBAL));
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		// A short gimbal frame rewrites two bytes and picks up the stale rest.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h02);
		send_byte(8'(cfp_pkg::CMD_GIMBAL));
		send_byte(8'h11);
		send_byte(8'h22);
		// Fire and chassis commands each take payload byte zero.
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h01);
		send_byte(8'(cfp_pkg::CMD_FIRE));
		send_byte(8'hFF);
		send_byte(cfp_pkg::HEADER_RESET);
		send_byte(8'h01);
		send_byte(8'(cfp_pkg::CMD_CHASSIS));
		send_byte(8'h3C);

		// Random frames, first under the reset header and then under a series
		// of written header values, the extremes among them.
		header_plan[0] = 8'h00;
		header_plan[1] = 8'hFF;
		header_plan[2] = 8'($urandom);
		header_plan[3] = cfp_pkg::HEADER_RESET;
		target = bytes_sent + RANDOM_BYTES / 5;
		while (bytes_sent < target)
			send_frame();
		foreach (header_plan[p]) begin
			write_header(header_plan[p]);
			// In one phase the result side holds off for a long stretch while
			// zero-length frames keep coming, so the block must stall its input.
			if (p == 2) begin
				hold_rx = 1'b1;
				burst_left = 1000;
				repeat (30) begin
					send_byte(sb.header);
					send_byte(8'h00);
					send_byte(8'($urandom_range(0, int'(cfp_pkg::MAX_CMD))));
				end
				burst_left = 0;
			end
			target = bytes_sent + RANDOM_BYTES / 5;
			while (bytes_sent < target)
				send_frame();
		end

		// Wind down: collect what is outstanding, wait a further settle time for
		// anything unexpected, then flag leftovers.
		drain_results();
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));

		$display("Sent %0d bytes under %0d header values; %0d command results checked.",
			bytes_sent, headers_used, sb.frames_checked);
		$display("Included zero-length, bad length, bad command, stale payload and stall runs.");
		if (sb.fails == 0) begin
			$display("command_frame_parser_core verification clean");
		end else begin
			$display("%0d mismatches", sb.fails);
			$display("command_frame_parser_core verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/cfp_pkg.sv
rtl/cfp_if.sv
rtl/cfp_parser.sv
rtl/cfp_hold.sv
rtl/command_frame_parser_core.sv
dv/tb_command_frame_parser_core.sv
